@@ src/anms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anms_pkg
// Shared types and constants for the per-class adaptive NMS block.
// ----------------------------------------------------------------------------
package anms_pkg;

  localparam int unsigned ProdW   = 85;  // widest product: union * limit
  localparam int unsigned McandW  = 68;
  localparam int unsigned MplierW = 34;
  localparam int unsigned GeoW    = 35;  // signed corner arithmetic
  localparam int unsigned ExtW    = 33;  // extent magnitude

  localparam logic [16:0] IouLimitRst = 17'd32768;
  localparam logic [16:0] EtaOne      = 17'd65536;
  localparam logic [16:0] HalfQ16     = 17'd32768;
  localparam int unsigned PixOne      = 65536;
  localparam int unsigned ResultCap   = 64;

  typedef struct packed {
    logic [15:0] score;
    logic [31:0] bottom;
    logic [31:0] right;
    logic [31:0] top;
    logic [31:0] left;
  } box_t;

  typedef struct packed {
    logic               start;
    logic [McandW-1:0]  mcand;
    logic [MplierW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] product;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    REG_IOU_LIMIT  = 3'd0,
    REG_SCORE_FLOOR = 3'd1,
    REG_DECAY_ETA  = 3'd2,
    REG_TOP_K      = 3'd3,
    REG_NORMALIZED = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RANK_RD_I,
    S_RANK_LAT_I,
    S_RANK_RD_J,
    S_RANK_CMP,
    S_RANK_WR,
    S_NMS_RD_SORT,
    S_NMS_RD_A,
    S_NMS_LAT_A,
    S_PAIR_RD_K,
    S_PAIR_RD_B,
    S_PAIR_LAT_B,
    S_GEOM,
    S_MUL_I,
    S_MUL_A,
    S_MUL_B,
    S_MUL_R,
    S_PAIR_NEXT,
    S_DECIDE,
    S_OUT_START,
    S_OUT_RD_K,
    S_OUT_RD_B,
    S_OUT_EMIT
  } state_e;

endpackage

@@ src/anms_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module anms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/anms_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anms_mul
// Shared shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module anms_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  anms_pkg::mul_req_t  req_i,
  output anms_pkg::mul_rsp_t  rsp_o
);
  import anms_pkg::*;

  logic               busy_q;
  logic [ProdW-1:0]   mc_q;
  logic [MplierW-1:0] mp_q;
  logic [ProdW-1:0]   acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && (mp_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mc_q  <= ProdW'(req_i.mcand);
      mp_q  <= req_i.mplier;
      acc_q <= '0;
    end else if (busy_q && (mp_q != '0)) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign rsp_o.done    = busy_q && (mp_q == '0);
  assign rsp_o.product = acc_q;

endmodule

@@ src/adaptive_nms_per_class_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_nms_per_class_top
// Per-class NMS with adaptive IoU threshold, bit-serial overlap arithmetic.
// ----------------------------------------------------------------------------
// A box is loaded when start is high while busy is low. The box with
// final_box set raises busy until the whole set is done. Ranking compares
// every loaded box at or above the score floor with every loaded box.
// Each IoU test of two boxes with nonzero area runs four products through
// one shift-add multiplier, one multiplier bit per cycle; a candidate is
// tested against each kept box until one reaches the IoU limit (only the
// latest one when its score equals the floor). Each result is shown on the
// result ports for one cycle with result_strobe_o; it cannot be stalled.
// ----------------------------------------------------------------------------
module adaptive_nms_per_class_top #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] top_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] bottom_i,
  input  logic [15:0]        box_score_i,
  input  logic               final_box_i,
  output logic               result_strobe_o,
  output logic [5:0]         kept_index_o,
  output logic [15:0]        kept_score_o,
  output logic signed [31:0] kept_left_o,
  output logic signed [31:0] kept_top_o,
  output logic signed [31:0] kept_right_o,
  output logic signed [31:0] kept_bottom_o,
  output logic               is_valid_o,
  output logic               run_end_o
);
  import anms_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_BOXES);
  localparam int unsigned CW   = $clog2(MAX_BOXES + 1);
  localparam int unsigned CmpW = (CW > 8) ? CW : 8;

  state_e state_q, state_d;

  logic [16:0] iou_limit_q, decay_eta_q;
  logic [15:0] score_floor_q;
  logic [7:0]  top_k_q;
  logic        normalized_q;

  logic [CW-1:0] loaded_q, i_q, j_q, rank_q, cand_q, p_q, kept_q, k_q;
  logic [IW-1:0] a_idx_q, out_idx_q;
  logic [15:0]   si_q;
  box_t          a_q, b_q;
  logic          last_only_q, hit_q;
  logic [16:0]   limit_q;
  logic [ExtW-1:0]   magax_q, magay_q, magbx_q, magby_q;
  logic [McandW-1:0] inter_q, area_a_q;

  logic        strobe_q, valid_q, run_end_q;
  box_t        out_box_q;
  logic [IW-1:0] out_idx_o_q;

  // RAM ports
  logic          box_we, sort_we, kept_we;
  logic [IW-1:0] box_raddr;
  box_t          box_wdata, box_rd;
  logic [IW-1:0] sort_rd, kept_rd;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // ---------------- geometry ----------------
  logic signed [GeoW-1:0] pix, al, at, ar, ab, bl, bt, br, bb;
  logic signed [GeoW-1:0] adx, ady, bdx, bdy, ix_raw, iy_raw;
  logic [ExtW-1:0]        ix, iy;
  logic                   apos, bpos;
  logic [McandW-1:0]      union_area;
  logic [ProdW-1:0]       lhs;
  logic [33:0]            decay_prod;
  logic                   load_ok, rank_bump, topk_cut, out_last;
  logic [CW:0]            k_inc;

  assign pix = normalized_q ? '0 : GeoW'(PixOne);
  assign al  = GeoW'($signed(a_q.left));
  assign at  = GeoW'($signed(a_q.top));
  assign ar  = GeoW'($signed(a_q.right));
  assign ab  = GeoW'($signed(a_q.bottom));
  assign bl  = GeoW'($signed(b_q.left));
  assign bt  = GeoW'($signed(b_q.top));
  assign br  = GeoW'($signed(b_q.right));
  assign bb  = GeoW'($signed(b_q.bottom));
  assign adx = ar - al + pix;
  assign ady = ab - at + pix;
  assign bdx = br - bl + pix;
  assign bdy = bb - bt + pix;
  assign apos = ((adx > 0) && (ady > 0)) || ((adx < 0) && (ady < 0));
  assign bpos = ((bdx > 0) && (bdy > 0)) || ((bdx < 0) && (bdy < 0));
  assign ix_raw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl) + pix;
  assign iy_raw = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt) + pix;
  assign ix = ix_raw[GeoW-1] ? '0 : ix_raw[ExtW-1:0];
  assign iy = iy_raw[GeoW-1] ? '0 : iy_raw[ExtW-1:0];

  assign union_area = area_a_q + mul_rsp.product[McandW-1:0] - inter_q;
  assign lhs        = {1'b0, inter_q, 16'h0000};
  assign decay_prod = limit_q * decay_eta_q;

  assign load_ok   = (loaded_q < CW'(MAX_BOXES));
  assign rank_bump = (box_rd.score >= score_floor_q) &&
                     ((box_rd.score > si_q) || ((box_rd.score == si_q) && (j_q < i_q)));
  assign topk_cut  = !top_k_q[7] && (CmpW'(top_k_q[6:0]) < CmpW'(cand_q));
  assign k_inc     = {1'b0, k_q} + 1'b1;
  assign out_last  = (k_inc == {1'b0, kept_q}) || (k_inc == (CW + 1)'(ResultCap));

  function automatic logic [ExtW-1:0] mag(input logic signed [GeoW-1:0] v);
    logic signed [GeoW-1:0] n;
    n = -v;
    return v[GeoW-1] ? n[ExtW-1:0] : v[ExtW-1:0];
  endfunction

  // ---------------- memories ----------------
  assign box_wdata = '{score: box_score_i, bottom: bottom_i, right: right_i,
                       top: top_i, left: left_i};

  anms_ram #(.Width($bits(box_t)), .Depth(MAX_BOXES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (loaded_q[IW-1:0]),
    .wdata_i (box_wdata),
    .raddr_i (box_raddr),
    .rdata_o (box_rd)
  );

  anms_ram #(.Width(IW), .Depth(MAX_BOXES)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (sort_we),
    .waddr_i (rank_q[IW-1:0]),
    .wdata_i (i_q[IW-1:0]),
    .raddr_i (p_q[IW-1:0]),
    .rdata_o (sort_rd)
  );

  anms_ram #(.Width(IW), .Depth(MAX_BOXES)) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (kept_q[IW-1:0]),
    .wdata_i (a_idx_q),
    .raddr_i (k_q[IW-1:0]),
    .rdata_o (kept_rd)
  );

  anms_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:        if (start && final_box_i) state_d = S_RANK_RD_I;
      S_RANK_RD_I:   state_d = (i_q == loaded_q) ? S_NMS_RD_SORT : S_RANK_LAT_I;
      S_RANK_LAT_I:  state_d = (box_rd.score < score_floor_q) ? S_RANK_RD_I : S_RANK_RD_J;
      S_RANK_RD_J:   state_d = (j_q == loaded_q) ? S_RANK_WR : S_RANK_CMP;
      S_RANK_CMP:    state_d = S_RANK_RD_J;
      S_RANK_WR:     state_d = S_RANK_RD_I;
      S_NMS_RD_SORT: state_d = (p_q == cand_q) ? S_OUT_START : S_NMS_RD_A;
      S_NMS_RD_A:    state_d = S_NMS_LAT_A;
      S_NMS_LAT_A:   state_d = (kept_q == '0) ? S_DECIDE : S_PAIR_RD_K;
      S_PAIR_RD_K:   state_d = S_PAIR_RD_B;
      S_PAIR_RD_B:   state_d = S_PAIR_LAT_B;
      S_PAIR_LAT_B:  state_d = S_GEOM;
      S_GEOM:        state_d = (apos && bpos) ? S_MUL_I : S_PAIR_NEXT;
      S_MUL_I:       if (mul_rsp.done) state_d = S_MUL_A;
      S_MUL_A:       if (mul_rsp.done) state_d = S_MUL_B;
      S_MUL_B:       if (mul_rsp.done) state_d = S_MUL_R;
      S_MUL_R:       if (mul_rsp.done) state_d = S_PAIR_NEXT;
      S_PAIR_NEXT:   state_d = (hit_q || last_only_q || (k_q == '0)) ? S_DECIDE : S_PAIR_RD_K;
      S_DECIDE:      state_d = S_NMS_RD_SORT;
      S_OUT_START:   state_d = (kept_q == '0) ? S_IDLE : S_OUT_RD_K;
      S_OUT_RD_K:    state_d = S_OUT_RD_B;
      S_OUT_RD_B:    state_d = S_OUT_EMIT;
      S_OUT_EMIT:    state_d = out_last ? S_IDLE : S_OUT_RD_K;
      default:       state_d = S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    box_we         = (state_q == S_IDLE) && start && load_ok;
    sort_we        = (state_q == S_RANK_WR);
    kept_we        = (state_q == S_DECIDE) && !hit_q;
    box_raddr      = '0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    unique case (state_q)
      S_RANK_RD_I: box_raddr = i_q[IW-1:0];
      S_RANK_RD_J: box_raddr = j_q[IW-1:0];
      S_NMS_RD_A:  box_raddr = sort_rd;
      S_PAIR_RD_B: box_raddr = kept_rd;
      S_OUT_RD_B:  box_raddr = kept_rd;
      S_GEOM: begin
        mul_req.start  = apos && bpos;
        mul_req.mcand  = McandW'(ix);
        mul_req.mplier = MplierW'(iy);
      end
      S_MUL_I: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = McandW'(magax_q);
        mul_req.mplier = MplierW'(magay_q);
      end
      S_MUL_A: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = McandW'(magbx_q);
        mul_req.mplier = MplierW'(magby_q);
      end
      S_MUL_B: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = union_area;
        mul_req.mplier = MplierW'(limit_q);
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      iou_limit_q   <= IouLimitRst;
      score_floor_q <= '0;
      decay_eta_q   <= EtaOne;
      top_k_q       <= 8'hFF;
      normalized_q  <= 1'b1;
      loaded_q      <= '0;
      i_q           <= '0;
      j_q           <= '0;
      rank_q        <= '0;
      cand_q        <= '0;
      p_q           <= '0;
      kept_q        <= '0;
      k_q           <= '0;
      hit_q         <= 1'b0;
      last_only_q   <= 1'b0;
      limit_q       <= IouLimitRst;
      strobe_q      <= 1'b0;
      valid_q       <= 1'b0;
      run_end_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_IOU_LIMIT:   iou_limit_q   <= cfg_wdata_i;
          REG_SCORE_FLOOR: score_floor_q <= cfg_wdata_i[15:0];
          REG_DECAY_ETA:   decay_eta_q   <= cfg_wdata_i;
          REG_TOP_K:       top_k_q       <= cfg_wdata_i[7:0];
          REG_NORMALIZED:  normalized_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (load_ok) loaded_q <= loaded_q + 1'b1;
            if (final_box_i) begin
              i_q    <= '0;
              cand_q <= '0;
            end
          end
        end
        S_RANK_RD_I: begin
          if (i_q == loaded_q) begin
            if (topk_cut) cand_q <= CW'(top_k_q[6:0]);
            p_q     <= '0;
            kept_q  <= '0;
            limit_q <= iou_limit_q;
          end
        end
        S_RANK_LAT_I: begin
          if (box_rd.score < score_floor_q) begin
            i_q <= i_q + 1'b1;
          end else begin
            j_q    <= '0;
            rank_q <= '0;
          end
        end
        S_RANK_CMP: begin
          if (rank_bump) rank_q <= rank_q + 1'b1;
          j_q <= j_q + 1'b1;
        end
        S_RANK_WR: begin
          cand_q <= cand_q + 1'b1;
          i_q    <= i_q + 1'b1;
        end
        S_NMS_LAT_A: begin
          hit_q       <= 1'b0;
          last_only_q <= (box_rd.score == score_floor_q);
          k_q         <= kept_q - 1'b1;
        end
        S_GEOM: begin
          if (!(apos && bpos)) hit_q <= (limit_q == '0);
        end
        S_MUL_R: begin
          if (mul_rsp.done) hit_q <= (lhs >= mul_rsp.product);
        end
        S_PAIR_NEXT: begin
          if (!(hit_q || last_only_q || (k_q == '0))) k_q <= k_q - 1'b1;
        end
        S_DECIDE: begin
          if (!hit_q) begin
            kept_q <= kept_q + 1'b1;
            if ((decay_eta_q < EtaOne) && (limit_q > HalfQ16)) begin
              limit_q <= decay_prod[32:16];
            end
          end
          p_q <= p_q + 1'b1;
        end
        S_OUT_START: begin
          loaded_q <= '0;
          k_q      <= '0;
          if (kept_q == '0) begin
            strobe_q  <= 1'b1;
            valid_q   <= 1'b0;
            run_end_q <= 1'b1;
          end
        end
        S_OUT_EMIT: begin
          strobe_q  <= 1'b1;
          valid_q   <= 1'b1;
          run_end_q <= out_last;
          k_q       <= k_inc[CW-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RANK_LAT_I: si_q <= box_rd.score;
      S_NMS_RD_A:   a_idx_q <= sort_rd;
      S_NMS_LAT_A:  a_q <= box_rd;
      S_PAIR_LAT_B: b_q <= box_rd;
      S_GEOM: begin
        magax_q <= mag(adx);
        magay_q <= mag(ady);
        magbx_q <= mag(bdx);
        magby_q <= mag(bdy);
      end
      S_MUL_I: if (mul_rsp.done) inter_q <= mul_rsp.product[McandW-1:0];
      S_MUL_A: if (mul_rsp.done) area_a_q <= mul_rsp.product[McandW-1:0];
      S_OUT_RD_B: out_idx_q <= kept_rd;
      S_OUT_START: begin
        if (kept_q == '0) begin
          out_box_q   <= '0;
          out_idx_o_q <= '0;
        end
      end
      S_OUT_EMIT: begin
        out_box_q   <= box_rd;
        out_idx_o_q <= out_idx_q;
      end
      default: ;
    endcase
  end

  assign result_strobe_o = strobe_q;
  assign kept_index_o    = 6'(out_idx_o_q);
  assign kept_score_o    = out_box_q.score;
  assign kept_left_o     = $signed(out_box_q.left);
  assign kept_top_o      = $signed(out_box_q.top);
  assign kept_right_o    = $signed(out_box_q.right);
  assign kept_bottom_o   = $signed(out_box_q.bottom);
  assign is_valid_o      = valid_q;
  assign run_end_o       = run_end_q;

  // ---------------- assertions ----------------
  a_empty_marker_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !is_valid_o |-> run_end_o)
    else $error("empty marker without run_end");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= p_q)
    else $error("kept count above candidate position");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_MUL_I) || (state_q == S_MUL_A) ||
                     (state_q == S_MUL_B) || (state_q == S_MUL_R))
    else $error("multiplier finished outside a product step");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && final_box_i))
    else $error("busy rose without a final box transfer");

endmodule
